FILE: hw/rtl/icc_pkg.sv
package icc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int NLINES     = 5;
    localparam int TAPS       = 25;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = 11;
    localparam int DIM_W   = 11;
    localparam int SLOT_W  = 3;
    localparam int TAP_W   = 5;
    localparam int COEF_W  = 13;
    localparam int ACC_W   = 23;
    localparam int SCALE_W = 17;
    localparam int PROD_W  = ACC_W + SCALE_W + 1;
    localparam int ADDR_W  = 4;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_KERNEL = 2'd2,
        REG_SCALE  = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        K_MEAN    = 3'd0,
        K_MOTION  = 3'd1,
        K_EDGE    = 3'd2,
        K_SHARPEN = 3'd3,
        K_EMBOSS  = 3'd4,
        K_GAUSS   = 3'd5
    } kernel_t;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [2:0]         ks;
        logic [1:0]         radius;
        logic [SCALE_W-1:0] scale;
    } cfg_t;

    typedef struct packed {
        logic                    shift;
        logic [NLINES-1:0][7:0]  column;
        logic                    step;
        logic [TAP_W-1:0]        tap;
        logic                    mult;
    } mac_ctrl_t;

    // 3x3 kernels sit in the lower right of the 5x5 window, since the window's
    // newest row and column are the current input position.
    localparam logic signed [COEF_W-1:0] COEF_Q8 [6][TAPS] = '{
        '{   0,   0,    0,    0,    0,
             0,   0,    0,    0,    0,
             0,   0,    0,  256,    0,
             0,   0,  256,  256,  256,
             0,   0,    0,  256,    0 },
        '{ 256,   0,    0,    0,    0,
             0, 256,    0,    0,    0,
             0,   0,  256,    0,    0,
             0,   0,    0,  256,    0,
             0,   0,    0,    0,  256 },
        '{   0,   0,    0,    0,    0,
             0,   0,    0,    0,    0,
             0,   0, -256, -256, -256,
             0,   0, -256, 2048, -256,
             0,   0, -256, -256, -256 },
        '{   0,   0,    0,    0,    0,
             0,   0,    0,    0,    0,
             0,   0, -256, -256, -256,
             0,   0, -256, 2304, -256,
             0,   0, -256, -256, -256 },
        '{   0,   0,    0,    0,    0,
             0,   0,    0,    0,    0,
             0,   0, -256, -256,    0,
             0,   0, -256,    0,  256,
             0,   0,    0,  256,  256 },
        '{   3,  32,   70,   32,    3,
            32, 334,  730,  334,   32,
            70, 730, 1594,  730,   70,
            32, 334,  730,  334,   32,
             3,  32,   70,   32,    3 }
    };

    function automatic logic signed [COEF_W-1:0] coef_q8(input logic [2:0] ks,
                                                         input logic [TAP_W-1:0] tap);
        return COEF_Q8[ks][tap];
    endfunction

    function automatic logic [1:0] radius_of(input logic [2:0] ks);
        return (ks == K_MOTION || ks == K_GAUSS) ? 2'd2 : 2'd1;
    endfunction

    // Line slot of the row that lies back rows above the row in slot s.
    function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
                                                    input logic [SLOT_W-1:0] back);
        logic [SLOT_W:0] t;
        t = {1'b0, s} + (SLOT_W+1)'(NLINES) - {1'b0, back};
        if (t >= (SLOT_W+1)'(NLINES))
            t = t - (SLOT_W+1)'(NLINES);
        return t[SLOT_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/icc_ram.sv
module icc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/icc_cfg.sv
module icc_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [icc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output icc_pkg::cfg_t              cfg,
    output logic                       restart
);

    logic [icc_pkg::DIM_W-1:0]   width_reg;
    logic [icc_pkg::DIM_W-1:0]   height_reg;
    logic [2:0]                  kernel_reg;
    logic [icc_pkg::SCALE_W-1:0] scale_reg;
    logic                        wr_en;
    icc_pkg::reg_index_t         idx;
    logic [2:0]                  ks_eff;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign idx     = icc_pkg::reg_index_t'(paddr[3:2]);
    assign restart = wr_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
            kernel_reg <= 3'd0;
            scale_reg  <= 17'd65536;
        end
        else if (wr_en)
        begin
            unique case (idx)
                icc_pkg::REG_WIDTH:  width_reg  <= pwdata[icc_pkg::DIM_W-1:0];
                icc_pkg::REG_HEIGHT: height_reg <= pwdata[icc_pkg::DIM_W-1:0];
                icc_pkg::REG_KERNEL: kernel_reg <= pwdata[2:0];
                icc_pkg::REG_SCALE:  scale_reg  <= pwdata[icc_pkg::SCALE_W-1:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            icc_pkg::REG_WIDTH:  prdata = {21'd0, width_reg};
            icc_pkg::REG_HEIGHT: prdata = {21'd0, height_reg};
            icc_pkg::REG_KERNEL: prdata = {29'd0, kernel_reg};
            icc_pkg::REG_SCALE:  prdata = {15'd0, scale_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign ks_eff = (kernel_reg > icc_pkg::K_GAUSS) ? icc_pkg::K_MEAN : kernel_reg;

    always_comb
    begin
        if (width_reg < 11'd3)
            cfg.width = 11'd3;
        else if (width_reg > 11'(icc_pkg::MAX_WIDTH))
            cfg.width = 11'(icc_pkg::MAX_WIDTH);
        else
            cfg.width = width_reg;
        if (height_reg < 11'd3)
            cfg.height = 11'd3;
        else if (height_reg > 11'(icc_pkg::MAX_HEIGHT))
            cfg.height = 11'(icc_pkg::MAX_HEIGHT);
        else
            cfg.height = height_reg;
        cfg.ks     = ks_eff;
        cfg.radius = icc_pkg::radius_of(ks_eff);
        cfg.scale  = scale_reg;
    end

endmodule

FILE: hw/rtl/icc_mac.sv
module icc_mac (
    input  logic                        clk,
    input  icc_pkg::mac_ctrl_t          ctrl,
    input  logic [2:0]                  ks,
    input  logic [icc_pkg::SCALE_W-1:0] scale,
    output logic [7:0]                  result
);

    logic [7:0]                              win_reg [icc_pkg::TAPS];
    logic signed [icc_pkg::ACC_W-1:0]        acc_reg;
    logic signed [icc_pkg::PROD_W-1:0]       prod_reg;
    logic signed [icc_pkg::COEF_W-1:0]       coef;
    logic signed [icc_pkg::COEF_W+8:0]       term;

    assign coef = icc_pkg::coef_q8(ks, ctrl.tap);
    assign term = coef * $signed({1'b0, win_reg[ctrl.tap]});

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            // Slide left one column; the fetched column enters on the right.
            for (int r = 0; r < icc_pkg::NLINES; r++)
            begin
                for (int c = 0; c < icc_pkg::NLINES - 1; c++)
                begin
                    win_reg[r*icc_pkg::NLINES + c] <= win_reg[r*icc_pkg::NLINES + c + 1];
                end
                win_reg[r*icc_pkg::NLINES + icc_pkg::NLINES - 1] <= ctrl.column[r];
            end
            acc_reg <= '0;
        end
        else if (ctrl.step && coef != '0)
        begin
            acc_reg <= acc_reg + icc_pkg::ACC_W'(term);
        end
        if (ctrl.mult)
        begin
            prod_reg <= acc_reg * $signed({1'b0, scale});
        end
    end

    always_comb
    begin
        if (prod_reg <= 0)
            result = 8'd0;
        else if (|prod_reg[icc_pkg::PROD_W-2:32])
            result = 8'd255;
        else
            result = prod_reg[31:24];
    end

endmodule

FILE: hw/rtl/image_kernel_convolution_core.sv
// Each taken pixel moves from S_IDLE to S_READ, where its window column is fetched;
// an item that releases no result then returns to S_IDLE, and a border result goes
// straight to S_OUT. An interior result steps the single multiply-accumulate over
// the 25 window taps in S_MAC, is scaled in S_MUL and is loaded in S_OUT, which waits
// while the output stalls. The input is stalled until the item is back in S_IDLE.
// Reset: asynchronous, clears positions and handshake state; line memories
// hold no reset value, and only data the current frame wrote enters a result.
module image_kernel_convolution_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 pixel,
    input  logic                       is_fill,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 out_pixel,
    output logic                       last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [icc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MAC  = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    localparam int CW = icc_pkg::COL_W;
    localparam int RW = icc_pkg::ROW_W;
    localparam int DW = icc_pkg::DIM_W;
    localparam int SW = icc_pkg::SLOT_W;

    icc_pkg::cfg_t      cfg;
    logic               restart;
    icc_pkg::mac_ctrl_t ctrl;
    logic [7:0]         mac_result;

    state_t                state_reg, state_next;
    logic [CW-1:0]         in_col_reg, in_col_next;
    logic [RW-1:0]         in_row_reg, in_row_next;
    logic [SW-1:0]         in_slot_reg, in_slot_next;
    logic [CW-1:0]         out_col_reg, out_col_next;
    logic [RW-1:0]         out_row_reg, out_row_next;
    logic [icc_pkg::TAP_W-1:0] tap_reg, tap_next;
    logic                  emit_reg, border_reg, item_last_reg;
    logic [7:0]            new_pix_reg;
    logic [SW-1:0]         slot_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_pixel_reg;
    logic                  out_last_reg;

    logic                  accept;
    logic                  emit, border, item_last, in_frame;
    logic [7:0]            wdata;
    logic [RW-1:0]         r_ext;
    logic [icc_pkg::NLINES-1:0][7:0] rdata;
    logic                  out_free;
    logic                  load_out;

    icc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign wdata    = is_fill ? 8'd0 : pixel;
    assign r_ext    = RW'(cfg.radius);
    assign in_frame = (in_row_reg < RW'(cfg.height)) && ({1'b0, in_col_reg} < cfg.width);

    assign emit = (in_row_reg > r_ext)
               || (in_row_reg == r_ext && in_col_reg >= CW'(cfg.radius));
    assign border = (out_row_reg < r_ext) || (out_col_reg < CW'(cfg.radius))
                 || (out_row_reg >= RW'(cfg.height - DW'(cfg.radius)))
                 || ({1'b0, out_col_reg} >= cfg.width - DW'(cfg.radius));
    assign item_last = (out_row_reg >= RW'(cfg.height - DW'(1)))
                    && ({1'b0, out_col_reg} >= cfg.width - DW'(1));

    for (genvar s = 0; s < icc_pkg::NLINES; s++)
    begin : g_line
        icc_ram #(
            .WIDTH (8),
            .DEPTH (icc_pkg::MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (accept && in_frame && in_slot_reg == SW'(s)),
            .waddr (in_col_reg),
            .wdata (wdata),
            .raddr (in_col_reg),
            .rdata (rdata[s])
        );
    end

    always_comb
    begin
        ctrl.shift = (state_reg == S_READ);
        for (int r = 0; r < icc_pkg::NLINES - 1; r++)
        begin
            ctrl.column[r] = rdata[icc_pkg::slot_back(slot_reg,
                                   SW'(icc_pkg::NLINES - 1 - r))];
        end
        ctrl.column[icc_pkg::NLINES-1] = new_pix_reg;
        ctrl.step = (state_reg == S_MAC);
        ctrl.tap  = tap_reg;
        ctrl.mult = (state_reg == S_MUL);
    end

    icc_mac u_mac (
        .clk    (clk),
        .ctrl   (ctrl),
        .ks     (cfg.ks),
        .scale  (cfg.scale),
        .result (mac_result)
    );

    // Position counters
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_slot_next = in_slot_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart || (accept && emit && item_last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_slot_next = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (emit)
            begin
                if ({1'b0, out_col_reg} + DW'(1) >= cfg.width)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
            if ({1'b0, in_col_reg} + DW'(1) >= cfg.width)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + RW'(1);
                in_slot_next = (in_slot_reg == SW'(icc_pkg::NLINES - 1)) ? '0
                             : in_slot_reg + SW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == S_OUT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_READ;
            end
            S_READ:
            begin
                tap_next = '0;
                if (!emit_reg)
                    state_next = S_IDLE;
                else if (border_reg)
                    state_next = S_OUT;
                else
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                tap_next = tap_reg + icc_pkg::TAP_W'(1);
                if (tap_reg == icc_pkg::TAP_W'(icc_pkg::TAPS - 1))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_reg       <= '0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_slot_reg <= in_slot_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the item's context for the fetch, compute and output phases, and load the output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_pix_reg   <= wdata;
            slot_reg      <= in_slot_reg;
            emit_reg      <= emit;
            border_reg    <= border;
            item_last_reg <= item_last;
        end
        if (load_out)
        begin
            out_pixel_reg <= border_reg ? 8'd0 : mac_result;
            out_last_reg  <= item_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign last      = out_last_reg;

endmodule

FILE: hw/rtl/icc_checker.sv
module icc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_pixel,
    input logic       last
);

    // A taken transaction makes the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in consecutive cycles");

    // A result appears only at the end of an item's processing
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled output dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_pixel) && $stable(last))
        else $error("stalled output changed");

endmodule

bind image_kernel_convolution_core icc_checker u_icc_checker (.*);
